@@ rtl/core/smc_pkg.sv @@
// ----------------------------------------------------------------------------
// smc_pkg
// Shared types and constants for the segment mean and centroid block.
// ----------------------------------------------------------------------------
package smc_pkg;

  localparam int unsigned MaxSegsDefault = 512;
  localparam int unsigned MaxDimDefault  = 1024;

  localparam int unsigned LabelW = 9;
  localparam int unsigned CoordW = 10;
  localparam int unsigned ColorW = 8;
  localparam int unsigned CsumW  = 28;
  localparam int unsigned PsumW  = 30;
  localparam int unsigned TallyW = 21;

  typedef enum logic [1:0] {
    ReqAccum = 2'd0,
    ReqQuery = 2'd1,
    ReqClear = 2'd2,
    ReqNone  = 2'd3
  } req_e;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    req_e              kind;
    logic [LabelW-1:0] label;
    logic              in_range;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [ColorW-1:0] blue;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] red;
  } cmd_t;

  // Queue status seen by the front end.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

@@ rtl/core/segment_mean_and_centroid.sv @@
// ----------------------------------------------------------------------------
// segment_mean_and_centroid
// Per-label mean color and centroid over a superpixel label map.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: a transaction is taken on a rising edge with start high
//   and busy low. req_type_i selects accumulate, query or clear; the label
//   and pixel fields ride along.
//   Result channel: only a query yields a result. It shows for exactly one
//   cycle with valid_o high; the receiver cannot hold it off.
//   Front end checks the request and pushes it into a two-entry command queue;
//   the back end drains it against a one-row-per-label table.
//   Steps: accumulate takes the back-end steps pop, read and write; clear
//   and the unused kind take pop and read, and the back end pops another
//   command only once back in idle. A query of a live label runs five
//   30-step divisions one after another on the shared restoring divider
//   before valid_o rises. An empty or out-of-range label answers with valid_o
//   after the read and load steps, without a division. busy rises only when
//   the queue is full.
//   Reset clears the live bits, so every label reads as empty; the sum
//   table itself is not cleared and needs no sweep.
//   Clear drops all live bits together, in its read step.
// ----------------------------------------------------------------------------
module segment_mean_and_centroid #(
  parameter int unsigned MaxSegs = smc_pkg::MaxSegsDefault,
  parameter int unsigned MaxDim  = smc_pkg::MaxDimDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 req_type_i,
  input  logic [smc_pkg::LabelW-1:0] seg_label_i,
  input  logic [smc_pkg::CoordW-1:0] pix_row_i,
  input  logic [smc_pkg::CoordW-1:0] pix_col_i,
  input  logic [smc_pkg::ColorW-1:0] pix_blue_i,
  input  logic [smc_pkg::ColorW-1:0] pix_green_i,
  input  logic [smc_pkg::ColorW-1:0] pix_red_i,
  output logic                       valid_o,
  output logic [smc_pkg::ColorW-1:0] mean_blue_o,
  output logic [smc_pkg::ColorW-1:0] mean_green_o,
  output logic [smc_pkg::ColorW-1:0] mean_red_o,
  output logic [smc_pkg::CoordW-1:0] centre_row_o,
  output logic [smc_pkg::CoordW-1:0] centre_col_o,
  output logic [smc_pkg::TallyW-1:0] seg_size_o,
  output logic                       seg_present_o
);
  import smc_pkg::*;

  cmd_t   push_cmd, head_cmd;
  qstat_t qstat;
  logic   push, pop;

  smc_front #(.MaxSegs(MaxSegs)) u_front (
    .clk_i, .rst_ni,
    .start_i     (start),
    .req_type_i, .seg_label_i, .pix_row_i, .pix_col_i,
    .pix_blue_i, .pix_green_i, .pix_red_i,
    .qstat_i     (qstat),
    .busy_o      (busy),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  smc_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .qstat_o (qstat)
  );

  smc_back #(.MaxSegs(MaxSegs), .MaxDim(MaxDim)) u_back (
    .clk_i, .rst_ni,
    .qstat_i (qstat),
    .cmd_i   (head_cmd),
    .pop_o   (pop),
    .valid_o, .mean_blue_o, .mean_green_o, .mean_red_o,
    .centre_row_o, .centre_col_o, .seg_size_o, .seg_present_o
  );

endmodule

@@ rtl/core/smc_front.sv @@
// ----------------------------------------------------------------------------
// smc_front
// Request intake: classifies a request and pushes it into the command queue.
// ----------------------------------------------------------------------------
module smc_front #(
  parameter int unsigned MaxSegs = smc_pkg::MaxSegsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [1:0]                  req_type_i,
  input  logic [smc_pkg::LabelW-1:0]  seg_label_i,
  input  logic [smc_pkg::CoordW-1:0]  pix_row_i,
  input  logic [smc_pkg::CoordW-1:0]  pix_col_i,
  input  logic [smc_pkg::ColorW-1:0]  pix_blue_i,
  input  logic [smc_pkg::ColorW-1:0]  pix_green_i,
  input  logic [smc_pkg::ColorW-1:0]  pix_red_i,
  input  smc_pkg::qstat_t             qstat_i,
  output logic                        busy_o,
  output logic                        push_o,
  output smc_pkg::cmd_t               cmd_o
);
  import smc_pkg::*;

  logic unused_clk;
  assign unused_clk = clk_i ^ rst_ni;

  assign busy_o = qstat_i.full;
  assign push_o = start_i && !qstat_i.full;

  always_comb begin
    cmd_o.kind     = req_e'(req_type_i);
    cmd_o.label    = seg_label_i;
    cmd_o.in_range = ({1'b0, seg_label_i} < (LabelW+1)'(MaxSegs)) ||
                     (MaxSegs > (1 << LabelW));
    cmd_o.row      = pix_row_i;
    cmd_o.col      = pix_col_i;
    cmd_o.blue     = pix_blue_i;
    cmd_o.green    = pix_green_i;
    cmd_o.red      = pix_red_i;
  end

endmodule

@@ rtl/core/smc_queue.sv @@
// ----------------------------------------------------------------------------
// smc_queue
// Two-entry command FIFO decoupling intake from the statistics engine.
// ----------------------------------------------------------------------------
module smc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  smc_pkg::cmd_t   cmd_i,
  input  logic            pop_i,
  output smc_pkg::cmd_t   cmd_o,
  output smc_pkg::qstat_t qstat_o
);
  import smc_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q, cnt_d;

  assign cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= cmd_i;
  end

  assign cmd_o         = mem_q[rp_q];
  assign qstat_o.full  = cnt_q[1];
  assign qstat_o.empty = (cnt_q == 2'd0);

endmodule

@@ rtl/core/smc_div.sv @@
// ----------------------------------------------------------------------------
// smc_div
// Shared restoring divider: one quotient bit per cycle, 30-bit dividend.
// ----------------------------------------------------------------------------
module smc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [smc_pkg::PsumW-1:0]  dividend_i,
  input  logic [smc_pkg::TallyW-1:0] divisor_i,
  output logic                       done_o,
  output logic [smc_pkg::PsumW-1:0]  quot_o
);
  import smc_pkg::*;

  localparam int unsigned CntW = $clog2(PsumW + 1);

  logic [PsumW-1:0]  quo_q;
  logic [TallyW:0]   rem_q;
  logic [TallyW-1:0] dvs_q;
  logic [CntW-1:0]   cnt_q;
  logic              run_q;
  logic              done_q;
  logic [TallyW+1:0] trial;

  assign trial = {rem_q, quo_q[PsumW-1]} - {2'b0, dvs_q};

  // done_q marks the cycle after the last step, when quo_q holds the quotient.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == CntW'(1));
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(PsumW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      if (!trial[TallyW+1]) begin
        rem_q <= trial[TallyW:0];
        quo_q <= {quo_q[PsumW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[TallyW-1:0], quo_q[PsumW-1]};
        quo_q <= {quo_q[PsumW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

@@ rtl/core/smc_back.sv @@
// ----------------------------------------------------------------------------
// smc_back
// Statistics engine: segment table, accumulate, clear and query division.
// ----------------------------------------------------------------------------
module smc_back #(
  parameter int unsigned MaxSegs = smc_pkg::MaxSegsDefault,
  parameter int unsigned MaxDim  = smc_pkg::MaxDimDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  smc_pkg::qstat_t            qstat_i,
  input  smc_pkg::cmd_t              cmd_i,
  output logic                       pop_o,
  output logic                       valid_o,
  output logic [smc_pkg::ColorW-1:0] mean_blue_o,
  output logic [smc_pkg::ColorW-1:0] mean_green_o,
  output logic [smc_pkg::ColorW-1:0] mean_red_o,
  output logic [smc_pkg::CoordW-1:0] centre_row_o,
  output logic [smc_pkg::CoordW-1:0] centre_col_o,
  output logic [smc_pkg::TallyW-1:0] seg_size_o,
  output logic                       seg_present_o
);
  import smc_pkg::*;

  localparam int unsigned Depth   = (MaxSegs < (1 << LabelW)) ? MaxSegs : (1 << LabelW);
  localparam int unsigned AddrW   = $clog2(Depth);
  localparam longint      CapFull = longint'(MaxDim) * longint'(MaxDim);
  localparam longint      TMax    = (longint'(1) << TallyW) - 1;
  localparam logic [TallyW-1:0] Cap = TallyW'((CapFull > TMax) ? TMax : CapFull);
  localparam int unsigned RowW    = 3*CsumW + 2*PsumW + TallyW;

  typedef enum logic [2:0] {
    StIdle, StRead, StLoad, StDiv, StOut
  } state_e;

  typedef struct packed {
    logic [CsumW-1:0]  b, g, r;
    logic [PsumW-1:0]  y, x;
    logic [TallyW-1:0] n;
  } row_t;

  row_t             mem_q [Depth];
  logic [Depth-1:0] live_q;
  row_t             rd_q;
  cmd_t             cur_q;
  state_e           st_q;
  logic [2:0]       fld_q;
  logic             lv_q;
  logic [ColorW-1:0] mb_q, mg_q, mr_q;
  logic [CoordW-1:0] cy_q, cx_q;
  logic [TallyW-1:0] sz_q;
  logic              pr_q;
  logic [AddrW-1:0]  addr;
  logic              div_go, div_done;
  logic [PsumW-1:0]  dvd, quo;
  row_t              wr;

  assign addr  = cur_q.label[AddrW-1:0];
  assign pop_o = (st_q == StIdle) && !qstat_i.empty;

  always_comb begin
    case (fld_q)
      3'd0:    dvd = PsumW'(rd_q.b);
      3'd1:    dvd = PsumW'(rd_q.g);
      3'd2:    dvd = PsumW'(rd_q.r);
      3'd3:    dvd = rd_q.y;
      default: dvd = rd_q.x;
    endcase
  end

  assign div_go = (st_q == StLoad) && lv_q && (rd_q.n != '0);

  smc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go || (div_done && fld_q != 3'd4)),
    .dividend_i (div_done ? (fld_q == 3'd0 ? PsumW'(rd_q.g) :
                             fld_q == 3'd1 ? PsumW'(rd_q.r) :
                             fld_q == 3'd2 ? rd_q.y : rd_q.x) : dvd),
    .divisor_i  (rd_q.n),
    .done_o     (div_done),
    .quot_o     (quo)
  );

  // Accumulate row: a fresh label loads the pixel, else sums add.
  always_comb begin
    if (!lv_q) begin
      wr.b = CsumW'(cur_q.blue);  wr.g = CsumW'(cur_q.green);
      wr.r = CsumW'(cur_q.red);   wr.y = PsumW'(cur_q.row);
      wr.x = PsumW'(cur_q.col);   wr.n = TallyW'(1);
    end else begin
      wr.b = rd_q.b + CsumW'(cur_q.blue);
      wr.g = rd_q.g + CsumW'(cur_q.green);
      wr.r = rd_q.r + CsumW'(cur_q.red);
      wr.y = rd_q.y + PsumW'(cur_q.row);
      wr.x = rd_q.x + PsumW'(cur_q.col);
      wr.n = rd_q.n + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StRead) rd_q <= mem_q[addr];
    if (st_q == StLoad && cur_q.kind == ReqAccum && cur_q.in_range &&
        (!lv_q || rd_q.n < Cap))
      mem_q[addr] <= wr;
    if (pop_o) cur_q <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      live_q <= '0;
      lv_q   <= 1'b0;
      fld_q  <= '0;
      pr_q   <= 1'b0;
      sz_q   <= '0;
      mb_q <= '0; mg_q <= '0; mr_q <= '0; cy_q <= '0; cx_q <= '0;
    end else begin
      case (st_q)
        StIdle: if (pop_o) st_q <= StRead;
        StRead: begin
          lv_q  <= live_q[addr] && cur_q.in_range;
          fld_q <= '0;
          case (cur_q.kind)
            ReqAccum: st_q <= cur_q.in_range ? StLoad : StIdle;
            ReqQuery: st_q <= StLoad;
            ReqClear: begin
              live_q <= '0;
              st_q   <= StIdle;
            end
            default: st_q <= StIdle;
          endcase
        end
        StLoad: begin
          fld_q <= '0;
          if (cur_q.kind == ReqAccum) begin
            live_q[addr] <= 1'b1;
            st_q <= StIdle;
          end else if (div_go) begin
            sz_q <= rd_q.n;
            pr_q <= 1'b1;
            st_q <= StDiv;
          end else begin
            mb_q <= '0; mg_q <= '0; mr_q <= '0; cy_q <= '0; cx_q <= '0;
            sz_q <= '0; pr_q <= 1'b0;
            st_q <= StOut;
          end
        end
        StDiv: if (div_done) begin
          case (fld_q)
            3'd0:    mb_q <= quo[ColorW-1:0];
            3'd1:    mg_q <= quo[ColorW-1:0];
            3'd2:    mr_q <= quo[ColorW-1:0];
            3'd3:    cy_q <= quo[CoordW-1:0];
            default: cx_q <= quo[CoordW-1:0];
          endcase
          fld_q <= fld_q + 1'b1;
          if (fld_q == 3'd4) st_q <= StOut;
        end
        StOut:   st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

  assign valid_o       = (st_q == StOut);
  assign mean_blue_o   = mb_q;
  assign mean_green_o  = mg_q;
  assign mean_red_o    = mr_q;
  assign centre_row_o  = cy_q;
  assign centre_col_o  = cx_q;
  assign seg_size_o    = sz_q;
  assign seg_present_o = pr_q;

  logic unused_w;
  assign unused_w = (RowW != 0);

endmodule

@@ rtl/core/smc_checker.sv @@
// ----------------------------------------------------------------------------
// smc_checker
// Port-level checks for the segment statistics block.
// ----------------------------------------------------------------------------
module smc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       valid_o,
  input logic [smc_pkg::ColorW-1:0] mean_blue_o,
  input logic [smc_pkg::TallyW-1:0] seg_size_o,
  input logic                       seg_present_o
);
  import smc_pkg::*;

  a_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe held");
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !seg_present_o |-> seg_size_o == '0 && mean_blue_o == '0)
    else $error("empty answer not zero");
  a_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && seg_present_o |-> seg_size_o != '0)
    else $error("present with zero size");

endmodule

bind segment_mean_and_centroid smc_checker u_chk (
  .clk_i, .rst_ni, .valid_o, .mean_blue_o, .seg_size_o, .seg_present_o
);

@@ sim/tb_segment_mean_and_centroid.sv @@
// ----------------------------------------------------------------------------
// tb_segment_mean_and_centroid
// Self-checking bench: accumulate, query, clear and unused-kind transactions
// go in through the start/busy handshake. Each query answer is checked field
// by field against a label table kept by the scoreboard.
// ----------------------------------------------------------------------------
module tb_segment_mean_and_centroid;
  timeunit 1ns;
  timeprecision 1ps;
  import smc_pkg::*;

  localparam int unsigned NumLabels = MaxSegsDefault;
  localparam longint unsigned FullCount = longint'(MaxDimDefault) * MaxDimDefault;
  localparam int unsigned IdleLimit = 4000;

  // One query answer as it shows on the result ports.
  typedef struct packed {
    logic [ColorW-1:0] blue;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] red;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [TallyW-1:0] size;
    logic              present;
  } stats_t;

  // Label table plus the queue of answers still owed by the block.
  class stats_scoreboard;
    logic [CsumW-1:0]  acc_blue[NumLabels];
    logic [CsumW-1:0]  acc_green[NumLabels];
    logic [CsumW-1:0]  red_sum[NumLabels];
    logic [PsumW-1:0]  row_sum[NumLabels];
    logic [PsumW-1:0]  col_sum[NumLabels];
    logic [TallyW-1:0] count[NumLabels];
    bit                live[NumLabels];
    stats_t            owed[$];
    int                errors;

    function new();
      errors = 0;
      foreach (live[i]) live[i] = 0;
    endfunction

    task report(input string what, input longint got, input longint want);
      errors++;
      $display("[%0t] mismatch %s: got %0d want %0d", $time, what, got, want);
    endtask

    // Called for every accepted request transaction.
    function void note_request(req_e kind, logic [LabelW-1:0] lbl,
                               logic [CoordW-1:0] r, logic [CoordW-1:0] c,
                               logic [ColorW-1:0] b, logic [ColorW-1:0] g,
                               logic [ColorW-1:0] rd);
      stats_t ans;
      longint unsigned n;
      case (kind)
        ReqAccum: begin
          if (!live[lbl]) begin
            // first pixel loads the row rather than adding
            acc_blue[lbl] = CsumW'(b); acc_green[lbl] = CsumW'(g);
            red_sum[lbl] = CsumW'(rd);
            row_sum[lbl] = PsumW'(r); col_sum[lbl] = PsumW'(c);
            count[lbl] = TallyW'(1); live[lbl] = 1;
          end else if (count[lbl] < FullCount) begin
            acc_blue[lbl] += CsumW'(b); acc_green[lbl] += CsumW'(g);
            red_sum[lbl] += CsumW'(rd);
            row_sum[lbl] += PsumW'(r); col_sum[lbl] += PsumW'(c);
            count[lbl] += TallyW'(1);
          end
        end
        ReqQuery: begin
          ans = '0;
          if (live[lbl] && count[lbl] != 0) begin
            n = count[lbl];
            ans.blue    = ColorW'(longint'(acc_blue[lbl]) / n);
            ans.green   = ColorW'(longint'(acc_green[lbl]) / n);
            ans.red     = ColorW'(longint'(red_sum[lbl]) / n);
            ans.row     = CoordW'(longint'(row_sum[lbl]) / n);
            ans.col     = CoordW'(longint'(col_sum[lbl]) / n);
            ans.size    = count[lbl];
            ans.present = 1'b1;
          end
          owed.push_back(ans);
        end
        ReqClear: foreach (live[i]) live[i] = 0;
        default: ;
      endcase
    endfunction

    task check_result(input stats_t got);
      stats_t want;
      if (owed.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        want = owed.pop_front();
        if (got.blue != want.blue) report("mean_blue", got.blue, want.blue);
        if (got.green != want.green) report("mean_green", got.green, want.green);
        if (got.red != want.red) report("mean_red", got.red, want.red);
        if (got.row != want.row) report("centre_row", got.row, want.row);
        if (got.col != want.col) report("centre_col", got.col, want.col);
        if (got.size != want.size) report("seg_size", got.size, want.size);
        if (got.present !== want.present)
          report("seg_present", got.present, want.present);
      end
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        req_type_i = '0;
  logic [LabelW-1:0] seg_label_i = '0;
  logic [CoordW-1:0] pix_row_i = '0;
  logic [CoordW-1:0] pix_col_i = '0;
  logic [ColorW-1:0] pix_blue_i = '0;
  logic [ColorW-1:0] pix_green_i = '0;
  logic [ColorW-1:0] pix_red_i = '0;
  logic              valid_o;
  stats_t            result;

  segment_mean_and_centroid uut (
    .clk_i, .rst_ni, .start, .busy,
    .req_type_i, .seg_label_i, .pix_row_i, .pix_col_i,
    .pix_blue_i, .pix_green_i, .pix_red_i,
    .valid_o,
    .mean_blue_o   (result.blue),
    .mean_green_o  (result.green),
    .mean_red_o    (result.red),
    .centre_row_o  (result.row),
    .centre_col_o  (result.col),
    .seg_size_o    (result.size),
    .seg_present_o (result.present)
  );

  always #6 clk_i = ~clk_i;

  stats_scoreboard sb = new();
  int idle_cycles = 0;
  int burst_left = 0;

  // Request monitor: a transaction is taken when start is high and busy low.
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy)
      sb.note_request(req_e'(req_type_i), seg_label_i, pix_row_i, pix_col_i,
                      pix_blue_i, pix_green_i, pix_red_i);
  end

  // Result monitor: the strobe lasts one cycle and cannot be stalled.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_result(result);
  end

  // Watchdog on cycles without any transaction on either side.
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Drive one request and hold it until taken. Gaps between bursts drop start.
  task send(input req_e kind, input logic [LabelW-1:0] lbl,
            input logic [CoordW-1:0] r, input logic [CoordW-1:0] c,
            input logic [ColorW-1:0] b, input logic [ColorW-1:0] g,
            input logic [ColorW-1:0] rd);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    start       <= 1'b1;
    req_type_i  <= kind;
    seg_label_i <= lbl;
    pix_row_i   <= r;
    pix_col_i   <= c;
    pix_blue_i  <= b;
    pix_green_i <= g;
    pix_red_i   <= rd;
    do @(posedge clk_i); while (busy);
  endtask

  task send_random_pixel(input logic [LabelW-1:0] lbl);
    send(ReqAccum, lbl, CoordW'($urandom_range(0, 1023)),
         CoordW'($urandom_range(0, 1023)), ColorW'($urandom_range(0, 255)),
         ColorW'($urandom_range(0, 255)), ColorW'($urandom_range(0, 255)));
  endtask

  task send_other(input req_e kind, input logic [LabelW-1:0] lbl);
    send(kind, lbl, CoordW'($urandom), CoordW'($urandom), ColorW'($urandom),
         ColorW'($urandom), ColorW'($urandom));
  endtask

  // Let the block finish all owed answers, then idle a little.
  task drain;
    start <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (sb.owed.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    int pick;
    logic [LabelW-1:0] lbl;
    logic [LabelW-1:0] pool[8];

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty queries, extreme pixels, extreme labels, clear, unused kind.
    send(ReqQuery, '0, '0, '0, '0, '0, '0);
    send(ReqQuery, '1, '0, '0, '0, '0, '0);
    send(ReqAccum, '0, '0, '0, '0, '0, '0);
    send(ReqQuery, '0, '0, '0, '0, '0, '0);
    send(ReqAccum, '1, '1, '1, '1, '1, '1);
    send(ReqQuery, '1, '0, '0, '0, '0, '0);
    send(ReqAccum, '1, '0, '0, '0, '0, '0);
    send(ReqAccum, '1, '1, '0, '1, '0, '1);
    send(ReqQuery, '1, '0, '0, '0, '0, '0);
    send(ReqNone, 9'd5, '1, '1, '1, '1, '1);   // must do nothing
    send(ReqQuery, 9'd5, '0, '0, '0, '0, '0);
    send(ReqClear, '0, '0, '0, '0, '0, '0);
    send(ReqQuery, '0, '0, '0, '0, '0, '0);
    send(ReqQuery, '1, '0, '0, '0, '0, '0);
    send(ReqAccum, '1, 10'd3, 10'd5, 8'd7, 8'd9, 8'd11);
    send(ReqQuery, '1, '0, '0, '0, '0, '0);

    // Pause until every owed answer is in.
    drain();

    // Random: mostly pixels into a small label pool so queries see real sums.
    foreach (pool[i]) pool[i] = LabelW'($urandom_range(0, NumLabels - 1));
    for (int k = 0; k < 400; k++) begin
      pick = $urandom_range(0, 99);
      lbl = ($urandom_range(0, 9) == 0) ? LabelW'($urandom_range(0, NumLabels - 1))
                                        : pool[$urandom_range(0, 7)];
      if (pick < 62) send_random_pixel(lbl);
      else if (pick < 94) send_other(ReqQuery, lbl);
      else if (pick < 97) send_other(ReqClear, lbl);
      else send_other(ReqNone, lbl);
      if (k == 200) drain();
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ segment_mean_and_centroid.f @@
rtl/core/smc_pkg.sv
rtl/core/smc_front.sv
rtl/core/smc_queue.sv
rtl/core/smc_div.sv
rtl/core/smc_back.sv
rtl/core/segment_mean_and_centroid.sv
rtl/core/smc_checker.sv
sim/tb_segment_mean_and_centroid.sv
